// ===== rtl/mexp_pkg.sv =====
package mexp_pkg;

    localparam int WIDTH  = 32;
    localparam int DATA_W = 32;
    localparam int PROD_W = 2 * WIDTH;
    localparam int CNT_W  = $clog2(PROD_W);

    localparam int S_TDATA_W = 2 * DATA_W;
    localparam int M_TDATA_W = DATA_W;

    typedef logic [WIDTH-1:0] t_word;
    typedef logic [PROD_W-1:0] t_prod;

endpackage

// ===== rtl/mexp_mulmod.sv =====
module mexp_mulmod (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  mexp_pkg::t_word i_a,
    input  mexp_pkg::t_word i_b,
    input  mexp_pkg::t_word i_modulus,
    output logic          o_done,
    output mexp_pkg::t_word o_result
);
    import mexp_pkg::*;

    typedef enum logic [2:0] {
        M_IDLE   = 3'b001,
        M_PROD   = 3'b010,
        M_REDUCE = 3'b100
    } t_mstate;

    t_mstate            r_state, n_state;
    t_word              r_a, r_b;
    t_prod              r_prod;
    t_word              r_rem;
    logic [CNT_W-1:0]   r_cnt;
    logic               r_done;
    t_word              r_result;

    logic [WIDTH:0]     w_trial;
    logic [WIDTH:0]     w_mod_ext;
    logic [WIDTH:0]     w_next_rem;

    assign w_trial    = {r_rem, r_prod[PROD_W-1]};
    assign w_mod_ext  = {1'b0, i_modulus};
    assign w_next_rem = (w_trial >= w_mod_ext) ? (w_trial - w_mod_ext) : w_trial;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            M_IDLE:   if (i_start) n_state = M_PROD;
            M_PROD:   n_state = M_REDUCE;
            M_REDUCE: if (r_cnt == '0) n_state = M_IDLE;
            default:  n_state = M_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= M_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done  <= (r_state == M_REDUCE) && (r_cnt == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            M_IDLE: begin
                if (i_start) begin
                    r_a <= i_a;
                    r_b <= i_b;
                end
            end
            M_PROD: begin
                r_prod <= PROD_W'(r_a) * PROD_W'(r_b);
                r_rem  <= '0;
                r_cnt  <= CNT_W'(PROD_W - 1);
            end
            M_REDUCE: begin
                r_rem  <= w_next_rem[WIDTH-1:0];
                r_prod <= {r_prod[PROD_W-2:0], 1'b0};
                r_cnt  <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    // modulus zero: the remainder ends as the low word of the product
                    r_result <= w_next_rem[WIDTH-1:0];
                end
            end
            default: ;
        endcase
    end

    assign o_done   = r_done;
    assign o_result = r_result;

endmodule

// ===== rtl/modular_exponentiation_core.sv =====
// Channel   Dir  Fields (lsb first)                      Size
// s_axis    in   base_value[31:0], exponent_value[31:0]  64 bits
// m_axis    out  power_result[31:0]                      32 bits
// cfg       in   modulus[31:0]                           32 bits
//
// Each modular multiply runs in the shared mulmod unit: start, the product step,
// 64 reduction steps and hand-back. An exponent of zero skips the multiplies
// and goes straight from idle to the done state.
// Reset (synchronous, active low) sets modulus to 1 and empties the output.
// s_axis_tready is high only when idle; one result may wait on m_axis, and a
// further finished request stalls in its last state until that one is taken.
module modular_exponentiation_core (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // base_value[31:0], exponent_value[63:32]
    input  logic [mexp_pkg::S_TDATA_W-1:0]   s_axis_tdata,
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // power_result[31:0]
    output logic [mexp_pkg::M_TDATA_W-1:0]   m_axis_tdata,
    input  logic                             i_cfg_we,
    input  logic [mexp_pkg::DATA_W-1:0]      i_cfg_wdata
);
    import mexp_pkg::*;

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_MUL   = 6'b000010,
        S_MUL_W = 6'b000100,
        S_SQR   = 6'b001000,
        S_SQR_W = 6'b010000,
        S_DONE  = 6'b100000
    } t_state;

    t_state  r_state, n_state;
    t_word   r_modulus;
    t_word   r_base, r_exp, r_acc, r_res;
    logic    r_out_valid;

    logic    w_in_acc;
    logic    w_out_load;
    logic    w_mm_start;
    t_word   w_mm_a;
    logic    w_mm_done;
    t_word   w_mm_result;
    t_word   w_in_exp;

    assign s_axis_tready = (r_state == S_IDLE);
    assign w_in_acc      = s_axis_tvalid && s_axis_tready;
    assign w_out_load    = (r_state == S_DONE) && (!r_out_valid || m_axis_tready);
    assign w_in_exp      = s_axis_tdata[DATA_W +: WIDTH];

    assign w_mm_start = ((r_state == S_MUL) && r_exp[0]) || (r_state == S_SQR);
    assign w_mm_a     = (r_state == S_MUL) ? r_acc : r_base;

    mexp_mulmod u_mulmod (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_mm_start),
        .i_a       (w_mm_a),
        .i_b       (r_base),
        .i_modulus (r_modulus),
        .o_done    (w_mm_done),
        .o_result  (w_mm_result)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (w_in_acc) n_state = (w_in_exp == '0) ? S_DONE : S_MUL;
            end
            S_MUL:   n_state = r_exp[0] ? S_MUL_W : S_SQR;
            S_MUL_W: begin
                if (w_mm_done) n_state = (r_exp[WIDTH-1:1] == '0) ? S_DONE : S_SQR;
            end
            S_SQR:   n_state = S_SQR_W;
            S_SQR_W: if (w_mm_done) n_state = S_MUL;
            S_DONE:  if (w_out_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_modulus   <= t_word'(1);
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) r_modulus <= i_cfg_wdata[WIDTH-1:0];
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_acc) begin
            r_base <= s_axis_tdata[WIDTH-1:0];
            r_exp  <= w_in_exp;
            r_acc  <= t_word'(1);
        end
        if ((r_state == S_MUL_W) && w_mm_done) r_acc <= w_mm_result;
        if ((r_state == S_SQR_W) && w_mm_done) begin
            r_base <= w_mm_result;
            r_exp  <= r_exp >> 1;
        end
        if (w_out_load) r_res <= r_acc;
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = M_TDATA_W'(r_res);

endmodule

// ===== sim/modular_exponentiation_core_test.sv =====
`timescale 1ns / 100ps

module modular_exponentiation_core_test;

    import mexp_pkg::*;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // base_value[31:0], exponent_value[63:32]
    logic [S_TDATA_W-1:0] s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // power_result[31:0]
    logic [M_TDATA_W-1:0] m_axis_tdata;
    logic                 i_cfg_we = 1'b0;
    logic [DATA_W-1:0]    i_cfg_wdata = '0;

    t_word  modulus_copy = 1;
    t_word  pending_powers[$];
    int     mismatch_count = 0;
    bit     idle_on = 1'b1;

    modular_exponentiation_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata)
    );

    always #6 i_clk = ~i_clk;

    function automatic t_prod reduce_product(t_prod a, t_prod b, t_word modv);
        t_prod p;
        p = a * b;
        if (modv == 0)
            return {{WIDTH{1'b0}}, p[WIDTH-1:0]};
        return p % {{WIDTH{1'b0}}, modv};
    endfunction

    // right-to-left square-and-multiply
    function automatic t_word power_mod(t_word base, t_word expo, t_word modv);
        t_prod acc;
        t_prod sq;
        acc = 1;
        sq  = {{WIDTH{1'b0}}, base};
        for (int i = 0; i < WIDTH; i++) begin
            if (expo[i])
                acc = reduce_product(acc, sq, modv);
            sq = reduce_product(sq, sq, modv);
        end
        return acc[WIDTH-1:0];
    endfunction

    function automatic t_word random_exponent();
        int    len;
        t_word e;
        len = $urandom_range(0, WIDTH);
        if (len == 0)
            return '0;
        e = $urandom;
        if (len < WIDTH)
            e = e & ((t_word'(1) << len) - 1);
        e[len-1] = 1'b1;
        return e;
    endfunction

    function automatic t_word random_base();
        case ($urandom_range(3))
            0: return $urandom_range(0, 15);
            1: return ~t_word'($urandom_range(0, 15));
            default: return $urandom;
        endcase
    endfunction

    task automatic send_request(t_word base, t_word expo);
        while (idle_on && $urandom_range(99) < 18) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {expo, base};
        @(posedge i_clk);
        while (!s_axis_tready)
            @(posedge i_clk);
        pending_powers.push_back(power_mod(base, expo, modulus_copy));
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_powers.size() != 0)
            @(posedge i_clk);
        repeat (80) @(posedge i_clk);
    endtask

    task automatic set_modulus(t_word value);
        wait_drained();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        modulus_copy = value;
        i_cfg_we <= 1'b0;
    endtask

    task automatic test_reset_modulus();
        send_request(32'd5, 32'd0);
        send_request(32'd5, 32'd3);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
    endtask

    task automatic test_small_modulus();
        set_modulus(32'd13);
        send_request(32'd0, 32'd0);
        send_request(32'd0, 32'd5);
        send_request(32'd2, 32'd10);
        send_request(32'd1, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFF, 32'd1);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(32'hAAAA_AAAA, 32'h5555_5555);
    endtask

    task automatic test_modulus_extremes();
        set_modulus(32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFE, 32'd2);
        send_request(32'h8000_0000, 32'h8000_0000);
        set_modulus(32'h8000_0000);
        send_request(32'd3, 32'hFFFF_FFFF);
        send_request(32'h5555_5555, 32'hAAAA_AAAA);
        set_modulus(32'd2);
        send_request(32'd7, 32'd9);
        send_request(32'd6, 32'd1);
        // no reduction: arithmetic wraps at the word width
        set_modulus(32'd0);
        send_request(32'd3, 32'hFFFF_FFFF);
        send_request(32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_request(32'd7, 32'd0);
        set_modulus(32'd1);
        send_request(32'd9, 32'd0);
        send_request(32'd9, 32'd4);
    endtask

    task automatic test_random_powers(int phases, int per_phase);
        t_word m;
        for (int ph = 0; ph < phases; ph++) begin
            case ($urandom_range(7))
                0: m = $urandom_range(1, 255);
                1: m = $urandom | 32'h8000_0000;
                2: m = (ph == 0) ? 32'd0 : $urandom;
                default: m = $urandom;
            endcase
            set_modulus(m);
            for (int n = 0; n < per_phase; n++)
                send_request(random_base(), random_exponent());
        end
    endtask

    task automatic test_back_to_back();
        idle_on = 1'b0;
        set_modulus($urandom);
        for (int n = 0; n < 20; n++)
            send_request(random_base(), random_exponent());
        wait_drained();
        idle_on = 1'b1;
    endtask

    always @(posedge i_clk)
        m_axis_tready <= !(idle_on && $urandom_range(99) < 18);

    always @(posedge i_clk) begin
        t_word want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_powers.size() == 0) begin
                mismatch_count++;
                if (mismatch_count <= 10)
                    $display("unexpected result %h", m_axis_tdata);
            end else begin
                want = pending_powers.pop_front();
                if (m_axis_tdata !== want) begin
                    mismatch_count++;
                    if (mismatch_count <= 10)
                        $display("power_result: expected %h, got %h", want, m_axis_tdata);
                end
            end
        end
    end

    initial begin
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_modulus();
        test_small_modulus();
        test_modulus_extremes();
        test_random_powers(3, 20);
        test_back_to_back();
        test_random_powers(2, 20);
        wait_drained();
        if (mismatch_count == 0)
            $display("modular_exponentiation_core_test: PASS");
        else
            $display("modular_exponentiation_core_test: FAIL");
        $finish;
    end

    initial begin
        #80000000;
        $display("modular_exponentiation_core_test: FAIL");
        $finish;
    end

endmodule
